// ===== hdl/utrl_pkg.sv =====
// Shared types, constants and codes for the unwind table range lookup block.
// No dependencies; imported by utrl_regs, utrl_engine and the top-level module.
`timescale 1ns / 1ps
`default_nettype none
package utrl_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int MAX_BLOCKS  = 1024;
  localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
  localparam int BLOCK_AW    = $clog2(MAX_BLOCKS);

  localparam logic [1:0] OP_WR_OFFSET = 2'd0;
  localparam logic [1:0] OP_WR_BLOCK  = 2'd1;
  localparam logic [1:0] OP_LOOKUP    = 2'd2;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NULL      = 3'd1;
  localparam logic [2:0] ST_BAD_IDX   = 3'd2;
  localparam logic [2:0] ST_BAD_VAL   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_WRITE     = 3'd5;

  localparam logic [2:0] REG_TABLE_BASE  = 3'd0;
  localparam logic [2:0] REG_ENTRY_COUNT = 3'd1;
  localparam logic [2:0] REG_FAST_START  = 3'd2;
  localparam logic [2:0] REG_FAST_STOP   = 3'd3;
  localparam logic [2:0] REG_BLOCK_SHIFT = 3'd4;
  localparam logic [2:0] REG_BLOCK_COUNT = 3'd5;
  localparam logic [2:0] REG_INIT_START  = 3'd6;
  localparam logic [2:0] REG_INIT_STOP   = 3'd7;

  typedef struct packed {
    logic [63:0] table_base;
    logic [12:0] entry_count;
    logic [63:0] fast_start;
    logic [63:0] fast_stop;
    logic [5:0]  block_shift;
    logic [10:0] block_count;
    logic [63:0] init_start;
    logic [63:0] init_stop;
  } utrl_cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] entry_index;
  } utrl_res_t;

endpackage
`default_nettype wire

// ===== hdl/utrl_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module utrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/utrl_regs.sv =====
// APB-style configuration register file for the lookup block.
// Depends on utrl_pkg for the register indexes and the config struct.
`timescale 1ns / 1ps
`default_nettype none
module utrl_regs
  import utrl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output utrl_cfg_t        cfg
);

  logic [63:0] table_base_r;
  logic [12:0] entry_count_r;
  logic [63:0] fast_start_r;
  logic [63:0] fast_stop_r;
  logic [5:0]  block_shift_r;
  logic [10:0] block_count_r;
  logic [63:0] init_start_r;
  logic [63:0] init_stop_r;
  logic        wr;
  logic [2:0]  sel;

  assign wr  = psel & penable & pwrite;
  assign sel = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_base_r  <= '0;
      entry_count_r <= '0;
      fast_start_r  <= '0;
      fast_stop_r   <= '0;
      block_shift_r <= 6'd8;
      block_count_r <= '0;
      init_start_r  <= '0;
      init_stop_r   <= '0;
    end else if (wr) begin
      unique case (sel)
        REG_TABLE_BASE:  table_base_r  <= pwdata;
        REG_ENTRY_COUNT: entry_count_r <= pwdata[12:0];
        REG_FAST_START:  fast_start_r  <= pwdata;
        REG_FAST_STOP:   fast_stop_r   <= pwdata;
        REG_BLOCK_SHIFT: block_shift_r <= pwdata[5:0];
        REG_BLOCK_COUNT: block_count_r <= pwdata[10:0];
        REG_INIT_START:  init_start_r  <= pwdata;
        REG_INIT_STOP:   init_stop_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_TABLE_BASE:  prdata = table_base_r;
      REG_ENTRY_COUNT: prdata = {51'd0, entry_count_r};
      REG_FAST_START:  prdata = fast_start_r;
      REG_FAST_STOP:   prdata = fast_stop_r;
      REG_BLOCK_SHIFT: prdata = {58'd0, block_shift_r};
      REG_BLOCK_COUNT: prdata = {53'd0, block_count_r};
      REG_INIT_START:  prdata = init_start_r;
      REG_INIT_STOP:   prdata = init_stop_r;
      default:         prdata = '0;
    endcase
  end

  assign cfg.table_base  = table_base_r;
  assign cfg.entry_count = entry_count_r;
  assign cfg.fast_start  = fast_start_r;
  assign cfg.fast_stop   = fast_stop_r;
  assign cfg.block_shift = block_shift_r;
  assign cfg.block_count = block_count_r;
  assign cfg.init_start  = init_start_r;
  assign cfg.init_stop   = init_stop_r;

endmodule
`default_nettype wire

// ===== hdl/utrl_alu.sv =====
// Shared 64-bit add/subtract unit with carry out (carry set means a >= b on subtract).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module utrl_alu (
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic        sub,
  output logic      [63:0] sum,
  output logic             cout
);

  logic [64:0] full;
  logic [63:0] b_op;

  assign b_op        = sub ? ~b : b;
  assign full        = {1'b0, a} + {1'b0, b_op} + {64'd0, sub};
  assign {cout, sum} = full;

endmodule
`default_nettype wire

// ===== hdl/utrl_engine.sv =====
// Lookup sequencer: window checks, block index reads and the binary search,
// all stepped through the shared utrl_alu. Depends on utrl_pkg, utrl_ram, utrl_alu.
`timescale 1ns / 1ps
`default_nettype none
module utrl_engine
  import utrl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  utrl_cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_op,
  input  wire logic [11:0]        in_slot,
  input  wire logic signed [31:0] in_offset_word,
  input  wire logic [12:0]        in_block_word,
  input  wire logic [63:0]        in_lookup_address,
  output logic                    res_valid,
  output utrl_res_t               res,
  input  wire logic               res_take
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FAST_LO = 4'd1;
  localparam logic [3:0] S_FAST_HI = 4'd2;
  localparam logic [3:0] S_IDX     = 4'd3;
  localparam logic [3:0] S_BLK0    = 4'd4;
  localparam logic [3:0] S_BLK1    = 4'd5;
  localparam logic [3:0] S_INIT_LO = 4'd6;
  localparam logic [3:0] S_INIT_HI = 4'd7;
  localparam logic [3:0] S_PROBE   = 4'd8;
  localparam logic [3:0] S_ADD     = 4'd9;
  localparam logic [3:0] S_CMP     = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0]          state_r, state_nxt;
  logic [63:0]         addr_r, addr_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic                ge_r, ge_nxt;
  logic [BLOCK_AW-1:0] idx_r, idx_nxt;
  logic [12:0]         start_r, start_nxt;
  logic signed [13:0]  first_r, first_nxt;
  logic signed [13:0]  last_r, last_nxt;
  logic [11:0]         mid_r, mid_nxt;
  logic [11:0]         found_r, found_nxt;
  utrl_res_t           res_r, res_nxt;

  logic [12:0]         n_w;
  logic [10:0]         b_w;
  logic                accept;
  logic [63:0]         alu_a, alu_b, alu_sum;
  logic                alu_sub, alu_cout;
  logic [63:0]         shifted;
  logic                bad_idx;
  logic [13:0]         span;
  logic [13:0]         mid_full;
  logic [11:0]         mid_w;
  logic [13:0]         stop_w;

  logic                off_we, off_re;
  logic [31:0]         off_rdata;
  logic                blk_we, blk_re;
  logic [BLOCK_AW-1:0] blk_raddr;
  logic [12:0]         blk_rdata;

  assign n_w = (cfg.entry_count > 13'(MAX_ENTRIES)) ? 13'(MAX_ENTRIES) : cfg.entry_count;
  assign b_w = (cfg.block_count > 11'(MAX_BLOCKS)) ? 11'(MAX_BLOCKS) : cfg.block_count;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  assign off_we = accept && (in_op == OP_WR_OFFSET);
  assign blk_we = accept && (in_op == OP_WR_BLOCK) && (in_slot[11:BLOCK_AW] == '0);

  utrl_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_off_ram (
    .clk   (clk),
    .we    (off_we),
    .waddr (in_slot[ENTRY_AW-1:0]),
    .wdata (in_offset_word),
    .re    (off_re),
    .raddr (mid_w[ENTRY_AW-1:0]),
    .rdata (off_rdata)
  );

  utrl_ram #(.WIDTH(13), .DEPTH(MAX_BLOCKS)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (in_slot[BLOCK_AW-1:0]),
    .wdata (in_block_word),
    .re    (blk_re),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  utrl_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum),
    .cout (alu_cout)
  );

  // midpoint of the live search range
  assign span     = 14'(last_r - first_r);
  assign mid_full = 14'(first_r) + {1'b0, span[13:1]};
  assign mid_w    = mid_full[11:0];

  assign shifted = acc_r >> cfg.block_shift;
  assign bad_idx = (b_w < 11'd2) || (shifted[63:BLOCK_AW] != '0)
                   || ({1'b0, shifted[BLOCK_AW-1:0]} >= (b_w - 11'd1));
  assign stop_w  = {1'b0, blk_rdata} + 14'd1;

  always_comb begin
    alu_a   = addr_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_FAST_LO: begin alu_b = cfg.fast_start; alu_sub = 1'b1; end
      S_FAST_HI: begin alu_b = cfg.fast_stop;  alu_sub = 1'b1; end
      S_INIT_LO: begin alu_b = cfg.init_start; alu_sub = 1'b1; end
      S_INIT_HI: begin alu_b = cfg.init_stop;  alu_sub = 1'b1; end
      S_PROBE: begin
        alu_a = cfg.table_base;
        alu_b = {50'd0, mid_w, 2'b00};
      end
      S_ADD: begin
        alu_a = acc_r;
        alu_b = {{32{off_rdata[31]}}, off_rdata};
      end
      S_CMP: begin alu_b = acc_r; alu_sub = 1'b1; end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    acc_nxt   = acc_r;
    ge_nxt    = ge_r;
    idx_nxt   = idx_r;
    start_nxt = start_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    mid_nxt   = mid_r;
    found_nxt = found_r;
    res_nxt   = res_r;
    off_re    = 1'b0;
    blk_re    = 1'b0;
    blk_raddr = shifted[BLOCK_AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          addr_nxt              = in_lookup_address;
          res_nxt.entry_index   = '0;
          state_nxt             = S_DONE;
          if (in_op == OP_WR_OFFSET || in_op == OP_WR_BLOCK) begin
            res_nxt.status = ST_WRITE;
          end else if (in_op == OP_LOOKUP) begin
            if (in_lookup_address == '0) begin
              res_nxt.status = ST_NULL;
            end else begin
              state_nxt = S_FAST_LO;
            end
          end else begin
            res_nxt.status = ST_NOT_FOUND;
          end
        end
      end
      S_FAST_LO: begin
        acc_nxt   = alu_sum;
        ge_nxt    = alu_cout;
        state_nxt = S_FAST_HI;
      end
      S_FAST_HI: begin
        state_nxt = (ge_r && !alu_cout) ? S_IDX : S_INIT_LO;
      end
      S_IDX: begin
        if (bad_idx) begin
          res_nxt.status = ST_BAD_IDX;
          state_nxt      = S_DONE;
        end else begin
          blk_re    = 1'b1;
          idx_nxt   = shifted[BLOCK_AW-1:0];
          state_nxt = S_BLK0;
        end
      end
      S_BLK0: begin
        start_nxt = blk_rdata;
        blk_re    = 1'b1;
        blk_raddr = idx_r + BLOCK_AW'(1);
        state_nxt = S_BLK1;
      end
      S_BLK1: begin
        if (start_r >= n_w || stop_w > {1'b0, n_w}) begin
          res_nxt.status = ST_BAD_VAL;
          state_nxt      = S_DONE;
        end else if (stop_w <= {1'b0, start_r}) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          first_nxt = $signed({1'b0, start_r});
          last_nxt  = $signed({1'b0, blk_rdata});
          found_nxt = start_r[11:0];
          state_nxt = S_PROBE;
        end
      end
      S_INIT_LO: begin
        ge_nxt    = alu_cout;
        state_nxt = S_INIT_HI;
      end
      S_INIT_HI: begin
        if (ge_r && !alu_cout && n_w != '0) begin
          first_nxt = '0;
          last_nxt  = $signed({1'b0, n_w}) - 14'sd1;
          found_nxt = '0;
          state_nxt = S_PROBE;
        end else begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end
      end
      S_PROBE: begin
        if (first_r <= last_r) begin
          off_re    = 1'b1;
          acc_nxt   = alu_sum;
          mid_nxt   = mid_w;
          state_nxt = S_ADD;
        end else begin
          res_nxt.status      = ST_FOUND;
          res_nxt.entry_index = found_r;
          state_nxt           = S_DONE;
        end
      end
      S_ADD: begin
        acc_nxt   = alu_sum;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (alu_cout) begin
          found_nxt = mid_r;
          first_nxt = $signed({2'b00, mid_r}) + 14'sd1;
        end else begin
          last_nxt = $signed({2'b00, mid_r}) - 14'sd1;
        end
        state_nxt = S_PROBE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    addr_r  <= addr_nxt;
    acc_r   <= acc_nxt;
    ge_r    <= ge_nxt;
    idx_r   <= idx_nxt;
    start_r <= start_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    mid_r   <= mid_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
  end

  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_FOUND) |-> ({1'b0, res.entry_index} < n_w))
    else $error("found index outside valid entries");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status != ST_FOUND) |-> (res.entry_index == '0))
    else $error("nonzero index on a non-found status");

  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (first_r <= last_r + 14'sd1))
    else $error("search range crossed over");

  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op != OP_LOOKUP) |=> (state_r == S_DONE))
    else $error("write transfer did not finish in one cycle");

endmodule
`default_nettype wire

// ===== hdl/unwind_table_range_lookup.sv =====
// Unwind table range lookup: takes one item at a time. A table write, an unused op or a
// lookup of address zero goes from the transfer to the engine's done state and then into
// the output register. A lookup in the fast window runs the window checks, the block index
// check and the two block index reads, one in the init window its window checks, and
// then each binary search probe (up to 13 for 4096 entries) an address sum, an offset add
// and a compare. All 64-bit window compares and address sums go through the one shared
// adder, and each probe waits on the registered read of the offset memory. The input
// channel stalls from the transfer until the result moves into the output register.
// Depends on utrl_pkg, utrl_regs and utrl_engine.
`timescale 1ns / 1ps
`default_nettype none
module unwind_table_range_lookup
  import utrl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic      [63:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_op,
  input  wire logic [11:0]        in_slot,
  input  wire logic signed [31:0] in_offset_word,
  input  wire logic [12:0]        in_block_word,
  input  wire logic [63:0]        in_lookup_address,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [2:0]         out_status,
  output logic      [11:0]        out_entry_index
);

  utrl_cfg_t  cfg;
  utrl_res_t  res;
  logic       res_valid;
  logic       res_take;
  logic       out_valid_r, out_valid_nxt;
  utrl_res_t  out_res_r, out_res_nxt;

  assign pready = 1'b1;

  utrl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  utrl_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_slot           (in_slot),
    .in_offset_word    (in_offset_word),
    .in_block_word     (in_block_word),
    .in_lookup_address (in_lookup_address),
    .res_valid         (res_valid),
    .res               (res),
    .res_take          (res_take)
  );

  // output register frees up when empty or when its transfer completes
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_entry_index = out_res_r.entry_index;

endmodule
`default_nettype wire

// ===== dv/unwind_table_range_lookup_test.sv =====
// Self-checking testbench for unwind_table_range_lookup: loads the table entries the
// directed corner lookups reach, then runs randomized table layouts against a local predictor.
// Depends on utrl_pkg and the unwind_table_range_lookup top level only.
`timescale 1ns / 1ps
module unwind_table_range_lookup_test;
  import utrl_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct {
    logic [1:0]  op;
    logic [11:0] slot;
    logic [31:0] offset_word;
    logic [12:0] block_word;
    logic [63:0] lookup_address;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [11:0] in_slot;
  logic [31:0] in_offset_word;
  logic [12:0] in_block_word;
  logic [63:0] in_lookup_address;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [11:0] out_entry_index;

  utrl_cfg_t   model_cfg;
  logic [31:0] offset_shadow [MAX_ENTRIES];
  logic [12:0] block_shadow [MAX_BLOCKS];
  utrl_res_t   pending_results[$];

  int unsigned send_idle_pct = 28;
  int unsigned stall_pct = 28;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned config_writes = 0;
  int unsigned status_tally [8];
  int unsigned quiet_cycles = 0;

  unwind_table_range_lookup dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_slot          (in_slot),
    .in_offset_word   (in_offset_word),
    .in_block_word    (in_block_word),
    .in_lookup_address(in_lookup_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_entry_index  (out_entry_index)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // predictor
  function automatic logic [63:0] entry_start(int unsigned i);
    logic [31:0] w;
    w = offset_shadow[i];
    return model_cfg.table_base + 64'(4 * i) + {{32{w[31]}}, w};
  endfunction

  function automatic int unsigned search_rightmost(int unsigned lo, int unsigned hi,
                                                   logic [63:0] addr);
    int first;
    int last;
    int mid;
    int unsigned found;
    first = int'(lo);
    last = int'(hi) - 1;
    found = lo;
    while (first <= last) begin
      mid = first + (last - first) / 2;
      if (entry_start(mid) <= addr) begin
        found = mid;
        first = mid + 1;
      end else begin
        last = mid - 1;
      end
    end
    return found;
  endfunction

  function automatic utrl_res_t predict_lookup(logic [63:0] addr);
    utrl_res_t   res;
    int unsigned n;
    int unsigned b;
    int unsigned blk_idx;
    int unsigned slice_lo;
    int unsigned slice_hi;
    logic [63:0] blk;
    res.status = ST_NOT_FOUND;
    res.entry_index = '0;
    n = (model_cfg.entry_count > MAX_ENTRIES) ? MAX_ENTRIES : model_cfg.entry_count;
    b = (model_cfg.block_count > MAX_BLOCKS) ? MAX_BLOCKS : model_cfg.block_count;
    if (addr == 64'd0) begin
      res.status = ST_NULL;
    end else if (addr >= model_cfg.fast_start && addr < model_cfg.fast_stop) begin
      blk = (addr - model_cfg.fast_start) >> model_cfg.block_shift;
      if (b < 2 || blk >= 64'(b - 1)) begin
        res.status = ST_BAD_IDX;
      end else begin
        blk_idx = int'(blk);
        slice_lo = block_shadow[blk_idx];
        slice_hi = int'(block_shadow[blk_idx + 1]) + 1;
        if (slice_lo >= n || slice_hi > n) begin
          res.status = ST_BAD_VAL;
        end else if (slice_hi > slice_lo) begin
          res.status = ST_FOUND;
          res.entry_index = 12'(search_rightmost(slice_lo, slice_hi, addr));
        end
      end
    end else if (addr >= model_cfg.init_start && addr < model_cfg.init_stop && n != 0) begin
      res.status = ST_FOUND;
      res.entry_index = 12'(search_rightmost(0, n, addr));
    end
    return res;
  endfunction

  function automatic utrl_res_t predict_result(request_t req);
    utrl_res_t res;
    res.status = ST_WRITE;
    res.entry_index = '0;
    case (req.op)
      OP_WR_OFFSET: offset_shadow[req.slot] = req.offset_word;
      OP_WR_BLOCK: if (req.slot < MAX_BLOCKS) block_shadow[req.slot] = req.block_word;
      OP_LOOKUP: res = predict_lookup(req.lookup_address);
      default: res.status = ST_NOT_FOUND;
    endcase
    status_tally[res.status]++;
    return res;
  endfunction

  // result checking
  task automatic flag_mismatch(string what, utrl_res_t want, utrl_res_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s) at %0t: expected status %0d index %0d, got status %0d index %0d",
               what, $time, want.status, want.entry_index, got.status, got.entry_index);
  endtask

  always @(posedge clk) begin : result_check
    utrl_res_t got;
    utrl_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.status = out_status;
      got.entry_index = out_entry_index;
      if (pending_results.size() == 0) begin
        flag_mismatch("no transfer pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) flag_mismatch("status", want, got);
        if (got.entry_index !== want.entry_index) flag_mismatch("entry_index", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // drivers
  function automatic request_t random_request();
    request_t r;
    r.op = OP_LOOKUP;
    r.slot = 12'($urandom);
    r.offset_word = $urandom;
    r.block_word = 13'($urandom_range(0, 4096));
    r.lookup_address = {$urandom, $urandom};
    return r;
  endfunction

  task automatic send_request(request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= req.op;
    in_slot <= req.slot;
    in_offset_word <= req.offset_word;
    in_block_word <= req.block_word;
    in_lookup_address <= req.lookup_address;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(req));
    items_sent++;
  endtask

  task automatic send_offset(int unsigned slot, logic [31:0] word);
    request_t req;
    req = random_request();
    req.op = OP_WR_OFFSET;
    req.slot = 12'(slot);
    req.offset_word = word;
    send_request(req);
  endtask

  task automatic send_block(int unsigned slot, logic [12:0] word);
    request_t req;
    req = random_request();
    req.op = OP_WR_BLOCK;
    req.slot = 12'(slot);
    req.block_word = word;
    send_request(req);
  endtask

  task automatic send_lookup(logic [63:0] addr);
    request_t req;
    req = random_request();
    req.lookup_address = addr;
    send_request(req);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] index, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_TABLE_BASE:  model_cfg.table_base = value;
      REG_ENTRY_COUNT: model_cfg.entry_count = value[12:0];
      REG_FAST_START:  model_cfg.fast_start = value;
      REG_FAST_STOP:   model_cfg.fast_stop = value;
      REG_BLOCK_SHIFT: model_cfg.block_shift = value[5:0];
      REG_BLOCK_COUNT: model_cfg.block_count = value[10:0];
      REG_INIT_START:  model_cfg.init_start = value;
      default:         model_cfg.init_stop = value;
    endcase
    config_writes++;
    @(posedge clk);
  endtask

  task automatic load_config(utrl_cfg_t c);
    write_register(REG_TABLE_BASE, c.table_base);
    write_register(REG_ENTRY_COUNT, 64'(c.entry_count));
    write_register(REG_FAST_START, c.fast_start);
    write_register(REG_FAST_STOP, c.fast_stop);
    write_register(REG_BLOCK_SHIFT, 64'(c.block_shift));
    write_register(REG_BLOCK_COUNT, 64'(c.block_count));
    write_register(REG_INIT_START, c.init_start);
    write_register(REG_INIT_STOP, c.init_stop);
  endtask

  // a table layout with its block index, then lookups, noise and a mid-phase drain
  task automatic run_layout_phase(int unsigned count, int unsigned lookups, bit scrambled);
    logic [63:0] starts[$];
    logic [31:0] words[$];
    logic [63:0] span;
    logic [63:0] mark_addr;
    utrl_cfg_t   plan;
    request_t    req;
    int          off;
    int unsigned shift;
    int unsigned blocks;
    int unsigned mark;
    int unsigned pick;
    plan.table_base = {$urandom, $urandom};
    if ($urandom_range(3) == 0)
      plan.table_base = 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 65535));
    off = int'($urandom_range(0, 2097152)) - 1048576;
    for (int unsigned i = 0; i < count; i++) begin
      words.push_back(scrambled ? $urandom : 32'(off));
      starts.push_back(plan.table_base + 64'(4 * i) + {{32{words[i][31]}}, words[i]});
      off = off + int'($urandom_range(0, 160)) - 4;
    end
    span = starts[count - 1] - starts[0] + 64'd64;
    shift = $urandom_range(2, 8);
    while ((span >> shift) > 64'd60) shift++;
    blocks = int'(span >> shift) + 2;
    plan.entry_count = 13'(count);
    plan.block_shift = 6'(shift);
    plan.block_count = 11'(blocks);
    plan.fast_start = starts[0] - 64'($urandom_range(0, 8));
    plan.fast_stop = plan.fast_start + (64'(blocks + 1) << shift);
    plan.init_start = plan.fast_start - 64'd256;
    plan.init_stop = starts[count - 1] + 64'd512;
    if (scrambled) begin
      plan.init_start = plan.table_base - 64'h8000_0000;
      plan.init_stop = plan.table_base + 64'h1_0000_0000;
    end
    wait_drain();
    load_config(plan);
    for (int unsigned i = 0; i < count; i++) send_offset(i, words[i]);
    for (int unsigned k = 0; k < blocks; k++) begin
      mark_addr = plan.fast_start + (64'(k) << shift);
      mark = 0;
      for (int unsigned i = 0; i < count; i++)
        if (starts[i] <= mark_addr) mark = i;
      send_block(k, 13'(mark));
    end
    for (int unsigned j = 0; j < lookups; j++) begin
      if (j == lookups / 2) wait_drain();
      pick = $urandom_range(99);
      req = random_request();
      if (pick < 70) begin
        req.lookup_address = starts[$urandom_range(0, count - 1)] - 64'd8 +
                             64'($urandom_range(0, 48));
      end else if (pick < 78) begin
        req.lookup_address = {$urandom, $urandom};
      end else if (pick < 82) begin
        req.lookup_address = 64'd0;
      end else if (pick < 90) begin
        case ($urandom_range(0, 6))
          0: req.lookup_address = plan.fast_start;
          1: req.lookup_address = plan.fast_start - 64'd1;
          2: req.lookup_address = plan.fast_stop - 64'd1;
          3: req.lookup_address = plan.fast_stop;
          4: req.lookup_address = plan.init_start;
          5: req.lookup_address = plan.init_stop - 64'd1;
          default: req.lookup_address = plan.init_stop;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: req.op = OP_WR_OFFSET;
          1: begin
            req.op = OP_WR_BLOCK;
            if ($urandom_range(1)) req.slot = 12'($urandom_range(0, blocks));
          end
          default: req.op = OP_UNUSED;
        endcase
      end
      send_request(req);
    end
  endtask

  // tests
  task automatic test_power_on();
    request_t req;
    send_lookup(64'd0);
    send_lookup(64'd1);
    send_lookup('1);
    req = random_request();
    req.op = OP_UNUSED;
    send_request(req);
  endtask

  // both table ends plus the right spine of a full-table search
  task automatic test_table_fill();
    int unsigned first;
    int unsigned last;
    int unsigned mid;
    for (int unsigned i = 0; i < 8; i++) send_offset(i, 32'(8 * i));
    for (int unsigned i = MAX_ENTRIES - 16; i < MAX_ENTRIES; i++) send_offset(i, 32'(8 * i));
    first = 0;
    last = MAX_ENTRIES - 1;
    while (first <= last) begin
      mid = first + (last - first) / 2;
      send_offset(mid, 32'(8 * mid));
      first = mid + 1;
    end
    for (int unsigned k = 0; k < 8; k++) send_block(k, 13'(4 * k));
    for (int unsigned k = MAX_BLOCKS - 8; k < MAX_BLOCKS; k++) send_block(k, 13'(4 * k));
  endtask

  task automatic test_directed_extremes();
    utrl_cfg_t c;
    request_t  req;
    wait_drain();
    c.table_base = 64'h1000;
    c.entry_count = 13'd4096;
    c.fast_start = 64'h1000;
    c.fast_stop = 64'h1000 + (64'd1024 << 6);
    c.block_shift = 6'd6;
    c.block_count = 11'd1024;
    c.init_start = 64'd1;
    c.init_stop = '1;
    load_config(c);
    send_offset(4095, 32'h7FFF_FFFF);
    send_offset(4094, 32'h8000_0000);
    send_block(1023, 13'd4096);
    send_block(4095, 13'd4096);
    send_block(5, 13'd30);
    send_block(6, 13'd10);
    send_lookup(64'h1000);
    send_lookup(64'h1000 + (64'd5 << 6) + 64'd3);
    send_lookup(64'h1000 + (64'd1021 << 6) + 64'd17);
    send_lookup(64'h1000 + (64'd1022 << 6));
    send_lookup(64'h1000 + (64'd1023 << 6));
    send_lookup(c.fast_stop);
    send_lookup('1);
    send_lookup(64'hFFFF_FFFF_FFFF_FFFE);
    send_lookup(64'd0);
    req.op = OP_UNUSED;
    req.slot = '1;
    req.offset_word = '1;
    req.block_word = 13'd4096;
    req.lookup_address = '1;
    send_request(req);

    wait_drain();
    c.table_base = '1;
    c.entry_count = 13'd0;
    c.fast_start = 64'd2;
    c.fast_stop = 64'h8000_0000_0000_0000;
    c.block_shift = 6'd63;
    c.block_count = 11'd1;
    c.init_start = 64'd0;
    c.init_stop = '1;
    load_config(c);
    send_lookup(64'd2);
    send_lookup(64'h7FFF_FFFF_FFFF_FFFF);
    send_lookup(64'd1);

    wait_drain();
    c.table_base = 64'd0;
    c.entry_count = 13'd4096;
    c.fast_start = 64'd100;
    c.fast_stop = 64'd101;
    c.block_shift = 6'd0;
    c.block_count = 11'd2;
    c.init_start = 64'd0;
    c.init_stop = 64'd0;
    load_config(c);
    send_lookup(64'd100);
    send_lookup(64'd101);
  endtask

  task automatic test_sorted_layouts();
    for (int p = 0; p < 4; p++) run_layout_phase((p == 3) ? 150 : $urandom_range(1, 48), 50, 0);
  endtask

  task automatic test_back_to_back();
    send_idle_pct = 0;
    stall_pct = 0;
    run_layout_phase($urandom_range(8, 48), 50, 0);
    send_idle_pct = 28;
    stall_pct = 28;
  endtask

  task automatic test_unsorted_table();
    run_layout_phase($urandom_range(16, 64), 50, 1);
  endtask

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    in_op <= OP_LOOKUP;
    in_slot <= '0;
    in_offset_word <= '0;
    in_block_word <= '0;
    in_lookup_address <= '0;
    model_cfg = '0;
    model_cfg.block_shift = 6'd8;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_power_on();
    test_table_fill();
    test_directed_extremes();
    test_sorted_layouts();
    test_back_to_back();
    test_unsorted_table();

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d input transfers and %0d register writes over 6 random layouts",
             items_sent, config_writes);
    $display("outcomes: found %0d, null %0d, bad index %0d, bad value %0d, none %0d, write %0d",
             status_tally[ST_FOUND], status_tally[ST_NULL], status_tally[ST_BAD_IDX],
             status_tally[ST_BAD_VAL], status_tally[ST_NOT_FOUND], status_tally[ST_WRITE]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_count,
               pending_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/utrl_pkg.sv
hdl/utrl_ram.sv
hdl/utrl_regs.sv
hdl/utrl_alu.sv
hdl/utrl_engine.sv
hdl/unwind_table_range_lookup.sv
dv/unwind_table_range_lookup_test.sv
